### sv/pftr_pkg.sv
// package for the page frame table replacer
// shared types, action and status codes, sequencer states; no dependencies
package pftr_pkg;

   localparam int NumFramesDefault = 64;

   typedef enum logic [1:0] {
      ACT_LOAD    = 2'd0,
      ACT_LOOKUP  = 2'd1,
      ACT_DIRTY   = 2'd2,
      ACT_REPLACE = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_NO_MATCH = 2'd1,
      ST_NO_VICT  = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_PROBE,
      S_WRITE,
      S_DONE
   } state_type;

   typedef struct packed {
      logic [1:0]  action;
      logic [5:0]  frame_slot;
      logic [31:0] virt_addr;
      logic [31:0] phys_addr;
      logic        dirty_in;
      logic [1:0]  seg_kind;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [31:0] phys_out;
      logic        swap_out_req;
      logic        evicted;
      logic [31:0] evict_vaddr;
   } rsp_type;

   typedef struct packed {
      logic [31:0] vaddr;
      logic [31:0] paddr;
      logic        dirty;
      logic        free;
      logic [1:0]  segtype;
   } entry_type;

endpackage

### sv/pftr_if.sv
// valid/ready channel interface carrying one item
// depends on nothing; payload type is a parameter
interface pftr_if #(parameter type payload_type = logic) (input logic clock);
   logic        valid;
   logic        ready;
   payload_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

### sv/pftr_table.sv
// frame table memory, one read port with registered data and one write port
// uses pftr_pkg; frames never written read as the reset entry via valid bits
module pftr_table #(
   parameter int NumFrames = pftr_pkg::NumFramesDefault,
   localparam int Aw = (NumFrames > 1) ? $clog2(NumFrames) : 1
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [Aw-1:0]         rd_addr,
   output pftr_pkg::entry_type   rd_data,
   input  logic                  wr_en,
   input  logic [Aw-1:0]         wr_addr,
   input  pftr_pkg::entry_type   wr_data
);
   pftr_pkg::entry_type mem [NumFrames];
   logic [NumFrames-1:0] valid_ff;
   pftr_pkg::entry_type  raw_ff;
   logic                 hit_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      raw_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         hit_ff   <= 1'b0;
      end else begin
         if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         hit_ff <= valid_ff[rd_addr];
      end
   end

   always_comb begin
      if (hit_ff) begin
         rd_data = raw_ff;
      end else begin
         rd_data = '{vaddr: 32'd0, paddr: raw_ff.paddr, dirty: 1'b1, free: 1'b1,
                     segtype: 2'd3};
      end
   end
endmodule

### sv/pftr_ctrl.sv
// sequencer: scans the frame table for lookup, set dirty, free claim and victim probe
// uses pftr_pkg; drives pftr_table ports
module pftr_ctrl #(
   parameter int NumFrames = pftr_pkg::NumFramesDefault,
   localparam int Aw = (NumFrames > 1) ? $clog2(NumFrames) : 1
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  pftr_pkg::req_type    req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output pftr_pkg::rsp_type    rsp_data,
   output logic [Aw-1:0]        rd_addr,
   input  pftr_pkg::entry_type  rd_data,
   output logic                 wr_en,
   output logic [Aw-1:0]        wr_addr,
   output pftr_pkg::entry_type  wr_data
);
   localparam logic [Aw:0] Last = (Aw+1)'(NumFrames - 1);

   pftr_pkg::state_type state_ff, state_in;
   pftr_pkg::req_type   req_ff, req_in;
   pftr_pkg::rsp_type   rsp_ff, rsp_in;
   pftr_pkg::entry_type hold_ff, hold_in;
   logic [Aw:0]   cnt_ff, cnt_in;
   logic [Aw-1:0] addr_ff, addr_in;
   logic [Aw-1:0] vp_ff, vp_in;
   logic [Aw-1:0] tgt_ff, tgt_in;
   logic          pend_ff, pend_in;
   logic          clean_ff, clean_in;
   logic          rvalid_ff, rvalid_in;
   logic          found_ff, found_in;
   logic [Aw-1:0] cur_ff, cur_in;

   logic [Aw-1:0] addr_nx;
   logic          match;
   logic          accept;

   assign accept    = req_valid && req_ready;
   assign req_ready = (state_ff == pftr_pkg::S_IDLE) && !pend_ff;
   assign rsp_valid = pend_ff;
   assign rsp_data  = rsp_ff;
   assign addr_nx   = (addr_ff == Last[Aw-1:0]) ? '0 : addr_ff + 1'b1;

   always_comb begin
      case (pftr_pkg::action_type'(req_ff.action))
         pftr_pkg::ACT_LOOKUP:  match = rd_data.vaddr == req_ff.virt_addr;
         pftr_pkg::ACT_DIRTY:   match = rd_data.paddr == req_ff.phys_addr;
         pftr_pkg::ACT_REPLACE: match = rd_data.free;
         default:               match = 1'b0;
      endcase
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         pftr_pkg::S_IDLE: begin
            if (accept) begin
               if (req_data.action == pftr_pkg::ACT_LOAD) state_in = pftr_pkg::S_DONE;
               else state_in = pftr_pkg::S_SCAN;
            end
         end
         pftr_pkg::S_SCAN: begin
            if (rvalid_ff && match) state_in = pftr_pkg::S_WRITE;
            else if (rvalid_ff && cnt_ff == Last) begin
               if (req_ff.action == pftr_pkg::ACT_REPLACE) state_in = pftr_pkg::S_PROBE;
               else state_in = pftr_pkg::S_DONE;
            end
         end
         pftr_pkg::S_PROBE: begin
            if (rvalid_ff && ((clean_ff && !rd_data.dirty) ||
                              (!clean_ff && rd_data.segtype != 2'd0)))
               state_in = pftr_pkg::S_WRITE;
            else if (rvalid_ff && cnt_ff == Last) state_in = pftr_pkg::S_DONE;
         end
         pftr_pkg::S_WRITE: state_in = pftr_pkg::S_IDLE;
         pftr_pkg::S_DONE:  state_in = pftr_pkg::S_IDLE;
         default:           state_in = pftr_pkg::S_IDLE;
      endcase
   end

   always_comb begin
      req_in    = req_ff;
      rsp_in    = rsp_ff;
      hold_in   = hold_ff;
      cnt_in    = cnt_ff;
      addr_in   = addr_ff;
      vp_in     = vp_ff;
      tgt_in    = tgt_ff;
      pend_in   = pend_ff;
      clean_in  = clean_ff;
      rvalid_in = 1'b0;
      found_in  = found_ff;
      cur_in    = addr_ff;
      wr_en     = 1'b0;
      wr_addr   = tgt_ff;
      wr_data   = hold_ff;
      rd_addr   = addr_ff;
      if (pend_ff && rsp_ready) pend_in = 1'b0;
      case (state_ff)
         pftr_pkg::S_IDLE: begin
            if (accept) begin
               req_in    = req_data;
               addr_in   = '0;
               cnt_in    = '0;
               clean_in  = 1'b0;
               found_in  = 1'b0;
               rvalid_in = 1'b0;
            end
         end
         pftr_pkg::S_SCAN: begin
            rvalid_in = 1'b1;
            addr_in   = addr_nx;
            if (rvalid_ff) begin
               if (!rd_data.dirty) clean_in = 1'b1;
               if (match) begin
                  tgt_in    = cur_ff;
                  hold_in   = rd_data;
                  found_in  = 1'b0;
                  rvalid_in = 1'b0;
               end else if (cnt_ff == Last) begin
                  addr_in   = vp_ff;
                  cnt_in    = '0;
                  rvalid_in = 1'b0;
               end else begin
                  cnt_in = cnt_ff + 1'b1;
               end
            end
         end
         pftr_pkg::S_PROBE: begin
            rvalid_in = 1'b1;
            addr_in   = addr_nx;
            if (rvalid_ff) begin
               if ((clean_ff && !rd_data.dirty) ||
                   (!clean_ff && rd_data.segtype != 2'd0)) begin
                  tgt_in    = cur_ff;
                  hold_in   = rd_data;
                  found_in  = 1'b1;
                  rvalid_in = 1'b0;
               end else if (cnt_ff == Last) begin
                  rvalid_in = 1'b0;
               end else begin
                  cnt_in = cnt_ff + 1'b1;
               end
            end
         end
         pftr_pkg::S_WRITE: begin
            wr_en   = 1'b1;
            pend_in = 1'b1;
            rsp_in  = '0;
            case (pftr_pkg::action_type'(req_ff.action))
               pftr_pkg::ACT_LOOKUP: begin
                  wr_en           = 1'b0;
                  rsp_in.phys_out = hold_ff.paddr;
               end
               pftr_pkg::ACT_DIRTY: begin
                  wr_data         = hold_ff;
                  wr_data.dirty   = req_ff.dirty_in;
                  rsp_in.phys_out = req_ff.phys_addr;
               end
               default: begin
                  wr_data = '{vaddr: req_ff.virt_addr, paddr: hold_ff.paddr, dirty: 1'b0,
                              free: 1'b0, segtype: req_ff.seg_kind};
                  rsp_in.phys_out = hold_ff.paddr;
                  if (found_ff) begin
                     rsp_in.evicted      = 1'b1;
                     rsp_in.evict_vaddr  = hold_ff.vaddr;
                     rsp_in.swap_out_req = hold_ff.dirty || hold_ff.segtype != 2'd0;
                     vp_in = (tgt_ff == Last[Aw-1:0]) ? '0 : tgt_ff + 1'b1;
                  end
               end
            endcase
         end
         pftr_pkg::S_DONE: begin
            pend_in = 1'b1;
            rsp_in  = '0;
            if (req_ff.action == pftr_pkg::ACT_LOAD) begin
               if ({26'd0, req_ff.frame_slot} < 32'(NumFrames)) begin
                  wr_en   = 1'b1;
                  wr_addr = Aw'(req_ff.frame_slot);
                  wr_data = '{vaddr: 32'd0, paddr: req_ff.phys_addr, dirty: 1'b1,
                              free: 1'b1, segtype: 2'd3};
               end else begin
                  rsp_in.status = pftr_pkg::ST_NO_MATCH;
               end
            end else if (req_ff.action == pftr_pkg::ACT_REPLACE) begin
               rsp_in.status = pftr_pkg::ST_NO_VICT;
            end else begin
               rsp_in.status = pftr_pkg::ST_NO_MATCH;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= pftr_pkg::S_IDLE;
         pend_ff   <= 1'b0;
         vp_ff     <= '0;
         rvalid_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         pend_ff   <= pend_in;
         vp_ff     <= vp_in;
         rvalid_ff <= rvalid_in;
      end
      req_ff   <= req_in;
      rsp_ff   <= rsp_in;
      hold_ff  <= hold_in;
      cnt_ff   <= cnt_in;
      addr_ff  <= addr_in;
      tgt_ff   <= tgt_in;
      clean_ff <= clean_in;
      found_ff <= found_in;
      cur_ff   <= cur_in;
   end
endmodule

### sv/page_frame_table_replacer.sv
// top level of the page frame table replacer
// uses pftr_pkg, pftr_if, pftr_table and pftr_ctrl
//
// req channel carries one item per action: load, lookup, set dirty, replace.
// rsp channel returns exactly one item per request item.
// the frame table sits in one synchronous memory read one frame per cycle.
// load writes its frame without a scan. lookup and set dirty scan frames in
// order. replace scans for the lowest free frame and, if none is free,
// probes from the victim pointer, all through the single memory read port.
// one item is worked on at a time; req_ready is low while one is in flight
// or while its result waits on rsp.
// reset clears the victim pointer and marks all frames as reset entries at
// once through per-frame valid bits; no clearing pass is needed.
// a stalled rsp holds its item until taken; no new item is accepted meanwhile.
module page_frame_table_replacer #(
   parameter int NumFrames = pftr_pkg::NumFramesDefault
) (
   input logic clock,
   input logic reset,
   pftr_if.sink   req,
   pftr_if.source rsp
);
   localparam int Aw = (NumFrames > 1) ? $clog2(NumFrames) : 1;

   logic [Aw-1:0]       rd_addr, wr_addr;
   logic                wr_en;
   pftr_pkg::entry_type rd_data, wr_data;

   pftr_table #(.NumFrames(NumFrames)) u_table (
      .clock, .reset, .rd_addr, .rd_data, .wr_en, .wr_addr, .wr_data
   );

   pftr_ctrl #(.NumFrames(NumFrames)) u_ctrl (
      .clock, .reset,
      .req_valid(req.valid), .req_ready(req.ready), .req_data(req.data),
      .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_data(rsp.data),
      .rd_addr, .rd_data, .wr_en, .wr_addr, .wr_data
   );
endmodule

### sv/pftr_checker.sv
// port-level checker for the page frame table replacer, bound to the top level
// uses pftr_pkg codes; sees only the top level's channels
module pftr_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input pftr_pkg::rsp_type rsp_data
);
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("item accepted while one in flight");
   a_no_ready_with_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("ready while result pending");
   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.status == pftr_pkg::ST_OK ||
                     rsp_data.status == pftr_pkg::ST_NO_MATCH ||
                     rsp_data.status == pftr_pkg::ST_NO_VICT))
      else $error("bad status");
   a_fail_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status != pftr_pkg::ST_OK) |->
      (rsp_data.phys_out == 32'd0 && !rsp_data.evicted && !rsp_data.swap_out_req))
      else $error("failed item carries data");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_data)))
      else $error("stalled item changed");
endmodule

bind page_frame_table_replacer pftr_checker u_pftr_checker (
   .clock, .reset,
   .req_valid(req.valid), .req_ready(req.ready),
   .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_data(rsp.data)
);

### test/tb.sv
// testbench for page_frame_table_replacer: directed and random actions, self-checking
// depends on pftr_pkg, pftr_if and the page_frame_table_replacer rtl
`timescale 1ns / 1ps

module tb;

   localparam int Frames = pftr_pkg::NumFramesDefault;
   localparam int Drain = 2 * Frames + 16;

   logic clock;
   logic reset;

   pftr_if #(.payload_type(pftr_pkg::req_type)) req (.clock(clock));
   pftr_if #(.payload_type(pftr_pkg::rsp_type)) rsp (.clock(clock));

   page_frame_table_replacer #(.NumFrames(Frames)) u_top (
      .clock(clock),
      .reset(reset),
      .req(req),
      .rsp(rsp)
   );

   logic [31:0] frame_vaddr [Frames];
   logic [31:0] frame_paddr [Frames];
   logic        frame_dirty [Frames];
   logic        frame_free [Frames];
   logic [1:0]  frame_seg [Frames];
   int unsigned victim_ptr;

   pftr_pkg::rsp_type expected_rsps [$];
   int mismatches = 0;
   int send_gap_pct = 0;
   int stall_pct = 0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #40ms;
      $display("end of test: mismatches");
      $finish;
   end

   function automatic pftr_pkg::rsp_type table_step(pftr_pkg::req_type r);
      pftr_pkg::rsp_type o;
      int victim;
      logic any_clean;
      o = '0;
      case (pftr_pkg::action_type'(r.action))
         pftr_pkg::ACT_LOAD: begin
            frame_paddr[r.frame_slot] = r.phys_addr;
            frame_vaddr[r.frame_slot] = '0;
            frame_dirty[r.frame_slot] = 1'b1;
            frame_free[r.frame_slot] = 1'b1;
            frame_seg[r.frame_slot] = 2'd3;
            o.status = pftr_pkg::ST_OK;
            return o;
         end
         pftr_pkg::ACT_LOOKUP: begin
            for (int i = 0; i < Frames; i++) begin
               if (frame_vaddr[i] == r.virt_addr) begin
                  o.status = pftr_pkg::ST_OK;
                  o.phys_out = frame_paddr[i];
                  return o;
               end
            end
            o.status = pftr_pkg::ST_NO_MATCH;
            return o;
         end
         pftr_pkg::ACT_DIRTY: begin
            for (int i = 0; i < Frames; i++) begin
               if (frame_paddr[i] == r.phys_addr) begin
                  frame_dirty[i] = r.dirty_in;
                  o.status = pftr_pkg::ST_OK;
                  o.phys_out = r.phys_addr;
                  return o;
               end
            end
            o.status = pftr_pkg::ST_NO_MATCH;
            return o;
         end
         default: begin
            for (int i = 0; i < Frames; i++) begin
               if (frame_free[i]) begin
                  frame_vaddr[i] = r.virt_addr;
                  frame_free[i] = 1'b0;
                  frame_dirty[i] = 1'b0;
                  frame_seg[i] = r.seg_kind;
                  o.status = pftr_pkg::ST_OK;
                  o.phys_out = frame_paddr[i];
                  return o;
               end
            end
            any_clean = 1'b0;
            for (int i = 0; i < Frames; i++) if (!frame_dirty[i]) any_clean = 1'b1;
            victim = -1;
            for (int k = 0; k < Frames && victim < 0; k++) begin
               int idx;
               idx = (victim_ptr + k) % Frames;
               if (any_clean ? !frame_dirty[idx] : frame_seg[idx] != 2'd0) victim = idx;
            end
            if (victim < 0) begin
               o.status = pftr_pkg::ST_NO_VICT;
               return o;
            end
            victim_ptr = (victim + 1) % Frames;
            o.status = pftr_pkg::ST_OK;
            o.phys_out = frame_paddr[victim];
            o.swap_out_req = frame_dirty[victim] || frame_seg[victim] != 2'd0;
            o.evicted = 1'b1;
            o.evict_vaddr = frame_vaddr[victim];
            frame_vaddr[victim] = r.virt_addr;
            frame_free[victim] = 1'b0;
            frame_dirty[victim] = 1'b0;
            frame_seg[victim] = r.seg_kind;
            return o;
         end
      endcase
   endfunction

   task automatic send_item(pftr_pkg::req_type r);
      while ($urandom_range(99) < send_gap_pct) @(negedge clock);
      @(negedge clock);
      req.valid <= 1'b1;
      req.data <= r;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
      expected_rsps.push_back(table_step(r));
      @(negedge clock);
      req.valid <= 1'b0;
   endtask

   task automatic send_action(pftr_pkg::action_type a, logic [5:0] slot, logic [31:0] va,
                              logic [31:0] pa, logic dv, logic [1:0] sk);
      pftr_pkg::req_type r;
      r.action = a;
      r.frame_slot = slot;
      r.virt_addr = va;
      r.phys_addr = pa;
      r.dirty_in = dv;
      r.seg_kind = sk;
      send_item(r);
   endtask

   always @(negedge clock) begin
      rsp.ready <= ($urandom_range(99) >= stall_pct);
   end

   always @(posedge clock) begin
      pftr_pkg::rsp_type want;
      if (!reset && rsp.valid && rsp.ready) begin
         if (expected_rsps.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected item %p", rsp.data);
         end else begin
            want = expected_rsps.pop_front();
            if (rsp.data.status !== want.status || rsp.data.phys_out !== want.phys_out
                || rsp.data.swap_out_req !== want.swap_out_req
                || rsp.data.evicted !== want.evicted
                || rsp.data.evict_vaddr !== want.evict_vaddr) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected %p actual %p", want, rsp.data);
            end
         end
      end
   end

   task automatic test_load_all();
      for (int i = 0; i < Frames; i++) begin
         logic [31:0] pa;
         pa = (i == 0) ? 32'h0 : (i == 1) ? 32'hffff_ffff : {$urandom} ^ i;
         send_action(pftr_pkg::ACT_LOAD, i[5:0], $urandom, pa, 1'($urandom),
                     2'($urandom));
      end
   endtask

   task automatic test_lookup_and_dirty();
      send_action(pftr_pkg::ACT_LOOKUP, 6'h3f, 32'h0, 32'h0, 1'b0, 2'd0);
      send_action(pftr_pkg::ACT_LOOKUP, 6'h00, 32'hffff_ffff, 32'h0, 1'b1, 2'd3);
      send_action(pftr_pkg::ACT_DIRTY, 6'h00, 32'h0, frame_paddr[5], 1'b0, 2'd0);
      send_action(pftr_pkg::ACT_DIRTY, 6'h00, 32'h0, 32'hdead_0001, 1'b1, 2'd0);
      send_action(pftr_pkg::ACT_DIRTY, 6'h00, 32'h0, 32'hffff_ffff, 1'b1, 2'd0);
   endtask

   task automatic test_fill_and_no_victim();
      for (int i = 0; i < Frames; i++)
         send_action(pftr_pkg::ACT_REPLACE, 6'($urandom),
                     (i == 0) ? 32'hffff_ffff : $urandom, $urandom, 1'($urandom), 2'd0);
      send_action(pftr_pkg::ACT_LOOKUP, 6'h0, 32'hffff_ffff, 32'h0, 1'b0, 2'd0);
      for (int i = 0; i < Frames; i++)
         send_action(pftr_pkg::ACT_DIRTY, 6'h0, 32'h0, frame_paddr[i], 1'b1, 2'd0);
      send_action(pftr_pkg::ACT_REPLACE, 6'h0, 32'h1234_5678, 32'h0, 1'b0, 2'd2);
      send_action(pftr_pkg::ACT_DIRTY, 6'h0, 32'h0, frame_paddr[40], 1'b0, 2'd0);
      send_action(pftr_pkg::ACT_REPLACE, 6'h0, 32'h0bad_cafe, 32'h0, 1'b0, 2'd1);
      send_action(pftr_pkg::ACT_REPLACE, 6'h0, 32'h0, 32'h0, 1'b0, 2'd3);
   endtask

   task automatic test_random(int count);
      for (int n = 0; n < count; n++) begin
         int pick;
         int f;
         logic [31:0] va;
         logic [31:0] pa;
         pick = $urandom_range(99);
         f = $urandom_range(Frames - 1);
         va = ($urandom_range(1)) ? frame_vaddr[f] : $urandom;
         pa = ($urandom_range(9) < 7) ? frame_paddr[f] : $urandom;
         if (pick < 8)
            send_action(pftr_pkg::ACT_LOAD, 6'($urandom), $urandom, $urandom,
                        1'($urandom), 2'($urandom));
         else if (pick < 28)
            send_action(pftr_pkg::ACT_LOOKUP, 6'($urandom), va, $urandom,
                        1'($urandom), 2'($urandom));
         else if (pick < 55)
            send_action(pftr_pkg::ACT_DIRTY, 6'($urandom), $urandom, pa,
                        1'($urandom), 2'($urandom));
         else
            send_action(pftr_pkg::ACT_REPLACE, 6'($urandom), $urandom, $urandom,
                        1'($urandom), 2'($urandom));
      end
   endtask

   initial begin
      int gap_pct [4];
      int stl_pct [4];
      gap_pct[0] = 0;
      gap_pct[1] = 64;
      gap_pct[2] = 0;
      gap_pct[3] = 11;
      stl_pct[0] = 0;
      stl_pct[1] = 0;
      stl_pct[2] = 64;
      stl_pct[3] = 11;
      for (int i = 0; i < Frames; i++) begin
         frame_vaddr[i] = '0;
         frame_paddr[i] = '0;
         frame_dirty[i] = 1'b1;
         frame_free[i] = 1'b1;
         frame_seg[i] = 2'd3;
      end
      victim_ptr = 0;
      reset = 1'b1;
      req.valid = 1'b0;
      req.data = '0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_load_all();
      test_lookup_and_dirty();
      test_fill_and_no_victim();
      for (int p = 0; p < 4; p++) begin
         send_gap_pct = gap_pct[p];
         stall_pct = stl_pct[p];
         test_random(400);
      end
      wait (expected_rsps.size() == 0);
      repeat (Drain) @(negedge clock);
      if (mismatches == 0 && expected_rsps.size() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
